### design/hslinv_pkg.sv
// shared types and constants for the hsl lightness inversion block
package hslinv_pkg;

  // one 8-bit colour or alpha channel
  typedef logic [7:0] chan_t;

  // width of the divider operands (largest divisor is six times 255)
  localparam int unsigned DEN_W = 11;

endpackage

### design/hslinv_if.sv
// pixel and result channel interfaces with valid/ready handshake
interface hslinv_pix_if;
  logic                valid;
  logic                ready;
  hslinv_pkg::chan_t   red;
  hslinv_pkg::chan_t   green;
  hslinv_pkg::chan_t   blue;
  hslinv_pkg::chan_t   alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

interface hslinv_res_if;
  logic                valid;
  logic                ready;
  hslinv_pkg::chan_t   out_red;
  hslinv_pkg::chan_t   out_green;
  hslinv_pkg::chan_t   out_blue;
  hslinv_pkg::chan_t   out_alpha;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

### design/hsl_lightness_invert_pixel_top.sv
// hsl lightness inversion of one rgba pixel per transaction
//
// in_px carries one pixel (red, green, blue, alpha); out_px carries the
// inverted pixel with alpha copied. Both use valid/ready: a transaction
// completes on a rising edge with valid and ready high.
// The pixel goes to hsl, lightness becomes one minus lightness, and the
// colour is rebuilt through the hue segments; gray pixels give the
// inverted gray level on all three channels.
// From input transaction to out_px.valid a pixel passes the front stages,
// the two dividers for saturation and hue that retire one quotient bit per
// stage, the back stages and the output register.
// Throughput is one pixel per cycle: every stage is registered and the
// pipeline moves whenever the output skid register is empty.
// When the receiver stalls, the result waits in the output register, one
// more result lands in the skid register, and then in_px.ready drops until
// the skid register drains; nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and output; no
// colour state survives between pixels.
module hsl_lightness_invert_pixel_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  hslinv_pix_if.sink           in_px,
  hslinv_res_if.source         out_px
);

  localparam int unsigned SW     = FRAC_BITS + 4;
  localparam int unsigned SIDE_W = FRAC_BITS + 10;
  localparam int unsigned DW     = hslinv_pkg::DEN_W;

  localparam logic [FRAC_BITS:0] ONE_FX   = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS:0] HALF_FX  = {2'b01, {(FRAC_BITS-1){1'b0}}};
  localparam logic [FRAC_BITS:0] THIRD_FX = (FRAC_BITS+1)'((64'd1 << FRAC_BITS) / 3);
  localparam logic [FRAC_BITS:0] TWO3_FX  = (FRAC_BITS+1)'((64'd2 << FRAC_BITS) / 3);
  localparam logic [FRAC_BITS:0] SIXTH_FX = (FRAC_BITS+1)'((64'd1 << FRAC_BITS) / 6);

  // lightness = sum * 2^(F-1) / 255 = sum * LUM_HI + sum * LUM_LO / 255
  localparam logic [FRAC_BITS-1:0] LUM_HI = FRAC_BITS'((64'd1 << (FRAC_BITS-1)) / 255);
  localparam logic [7:0]           LUM_LO = 8'((64'd1 << (FRAC_BITS-1)) % 255);
  // reciprocal of 255 for 17-bit values, underestimates by at most one
  localparam logic [17:0]          DIV255_MUL = 18'd131586;

  typedef enum logic [1:0] {SEG_RISE, SEG_HIGH, SEG_FALL, SEG_LOW} seg_t;

  logic en;

  // ---------------- front: min/max, lightness ----------------
  logic                 v_f1_r, v_f2_r, v_f3_r, v_f4_r;
  logic [8:0]           sum_f1_r, sum_nxt;
  logic [7:0]           d_f1_r, d_f2_r, d_f3_r, d_f4_r, d_nxt;
  logic [DW-1:0]        h6_f1_r, h6_f2_r, h6_f3_r, h6_f4_r, h6_nxt;
  logic [8:0]           dens_f1_r, dens_f2_r, dens_f3_r, dens_f4_r, dens_nxt;
  hslinv_pkg::chan_t    a_f1_r, a_f2_r, a_f3_r, a_f4_r;
  logic [16:0]          lx_f2_r, lx_f3_r, lx_nxt;
  logic [FRAC_BITS:0]   lhi_f2_r, lhi_f3_r, lhi_nxt;
  logic [8:0]           q0_f3_r, q0_nxt;
  logic [FRAC_BITS:0]   lum_f4_r, lum_nxt;

  logic [7:0]           mx, mn;
  logic [34:0]          mq;
  logic [16:0]          q0x255, lrem;

  // channel extremes, hue numerator in units of d, saturation divisor
  always_comb begin
    mx = in_px.red;
    mn = in_px.red;
    if (in_px.green > mx) mx = in_px.green;
    if (in_px.blue  > mx) mx = in_px.blue;
    if (in_px.green < mn) mn = in_px.green;
    if (in_px.blue  < mn) mn = in_px.blue;
    d_nxt   = mx - mn;
    sum_nxt = {1'b0, mx} + {1'b0, mn};
    if (mx == in_px.red) begin
      h6_nxt = {3'b000, in_px.green} - {3'b000, in_px.blue};
      if (in_px.green < in_px.blue) begin
        h6_nxt = h6_nxt + {1'b0, d_nxt, 2'b00} + {2'b00, d_nxt, 1'b0};
      end
    end else if (mx == in_px.green) begin
      h6_nxt = {3'b000, in_px.blue} - {3'b000, in_px.red} + {2'b00, d_nxt, 1'b0};
    end else begin
      h6_nxt = {3'b000, in_px.red} - {3'b000, in_px.green} + {1'b0, d_nxt, 2'b00};
    end
    // lightness above one half exactly when the sum exceeds 255
    dens_nxt = sum_nxt[8] ? (9'd510 - sum_nxt) : sum_nxt;
  end

  // lightness partial products, reciprocal and correction
  always_comb begin
    lx_nxt  = {8'b0, sum_f1_r} * {9'b0, LUM_LO};
    lhi_nxt = {{(FRAC_BITS-8){1'b0}}, sum_f1_r} * {1'b0, LUM_HI};
    mq      = {18'b0, lx_f2_r} * {17'b0, DIV255_MUL};
    q0_nxt  = mq[33:25];
    q0x255  = {q0_f3_r, 8'b0} - {8'b0, q0_f3_r};
    lrem    = lx_f3_r - q0x255;
    lum_nxt = lhi_f3_r + {{(FRAC_BITS-8){1'b0}}, q0_f3_r}
            + {{FRAC_BITS{1'b0}}, (lrem >= 17'd255)};
  end

  // front valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_f1_r <= 1'b0;
      v_f2_r <= 1'b0;
      v_f3_r <= 1'b0;
      v_f4_r <= 1'b0;
    end else if (en) begin
      v_f1_r <= in_px.valid;
      v_f2_r <= v_f1_r;
      v_f3_r <= v_f2_r;
      v_f4_r <= v_f3_r;
    end
  end

  // front payload
  always_ff @(posedge clk) begin
    if (en) begin
      sum_f1_r  <= sum_nxt;
      d_f1_r    <= d_nxt;
      h6_f1_r   <= h6_nxt;
      dens_f1_r <= dens_nxt;
      a_f1_r    <= in_px.alpha;
      lx_f2_r   <= lx_nxt;
      lhi_f2_r  <= lhi_nxt;
      d_f2_r    <= d_f1_r;
      h6_f2_r   <= h6_f1_r;
      dens_f2_r <= dens_f1_r;
      a_f2_r    <= a_f1_r;
      q0_f3_r   <= q0_nxt;
      lx_f3_r   <= lx_f2_r;
      lhi_f3_r  <= lhi_f2_r;
      d_f3_r    <= d_f2_r;
      h6_f3_r   <= h6_f2_r;
      dens_f3_r <= dens_f2_r;
      a_f3_r    <= a_f2_r;
      lum_f4_r  <= lum_nxt;
      d_f4_r    <= d_f3_r;
      h6_f4_r   <= h6_f3_r;
      dens_f4_r <= dens_f3_r;
      a_f4_r    <= a_f3_r;
    end
  end

  // ---------------- saturation and hue dividers ----------------
  logic [1:0][DW-1:0]       div_num, div_den;
  logic [SIDE_W-1:0]        div_side_in, div_side_out;
  logic                     div_valid;
  logic [1:0][FRAC_BITS:0]  div_quo;

  assign div_num[0]  = {3'b000, d_f4_r};
  assign div_den[0]  = {2'b00, dens_f4_r};
  assign div_num[1]  = h6_f4_r;
  assign div_den[1]  = {1'b0, d_f4_r, 2'b00} + {2'b00, d_f4_r, 1'b0};
  assign div_side_in = {(d_f4_r == 8'd0), a_f4_r, lum_f4_r};

  hslinv_div #(
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    (SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v_f4_r),
    .in_num    (div_num),
    .in_den    (div_den),
    .in_side   (div_side_in),
    .out_valid (div_valid),
    .out_quo   (div_quo),
    .out_side  (div_side_out)
  );

  // ---------------- back: rebuild the colour ----------------
  logic                    v_b1_r, v_b2_r, v_b3_r, v_b4_r;
  logic                    gray_b1_r, gray_b2_r, gray_b3_r, gray_b4_r;
  hslinv_pkg::chan_t       a_b1_r, a_b2_r, a_b3_r, a_b4_r;
  logic [FRAC_BITS:0]      linv_b1_r, sat_b1_r, prod_b1_r, linv_nxt, prod_nxt;
  logic                    lo_b1_r;
  logic [FRAC_BITS:0]      t_b1_r [3];
  logic [FRAC_BITS:0]      t_nxt  [3];
  logic signed [SW-1:0]    p_b2_r, q_b2_r, p_b3_r, q_b3_r, p_nxt, q_nxt;
  logic [FRAC_BITS+1:0]    span_b2_r, span_nxt;
  seg_t                    seg_b2_r [3];
  seg_t                    seg_b3_r [3];
  seg_t                    seg_nxt  [3];
  logic [FRAC_BITS:0]      f_b2_r   [3];
  logic [FRAC_BITS:0]      f_nxt    [3];
  logic [FRAC_BITS+2:0]    mul_b3_r [3];
  logic [FRAC_BITS+2:0]    mul_nxt  [3];
  hslinv_pkg::chan_t       byte_b4_r [3];
  hslinv_pkg::chan_t       byte_nxt  [3];

  logic [2*FRAC_BITS+1:0]  lp;
  logic signed [FRAC_BITS+2:0] hue_s, tr_s, tb_s;
  logic signed [SW-1:0]    linv_s, diff;
  logic [FRAC_BITS+3:0]    six_t;
  logic [FRAC_BITS:0]      dt;
  logic [2*FRAC_BITS+2:0]  mul_full;
  logic signed [SW-1:0]    val;
  logic [FRAC_BITS:0]      valu;
  logic [FRAC_BITS+8:0]    scaled;

  // inverted lightness, its product with saturation, wrapped hue offsets
  always_comb begin
    linv_nxt = ONE_FX - div_side_out[FRAC_BITS:0];
    lp       = {{(FRAC_BITS+1){1'b0}}, linv_nxt} * {{(FRAC_BITS+1){1'b0}}, div_quo[0]};
    prod_nxt = lp[2*FRAC_BITS:FRAC_BITS];
    hue_s    = signed'({2'b00, div_quo[1]});
    tr_s     = hue_s + signed'({2'b00, THIRD_FX});
    if (tr_s > signed'({2'b00, ONE_FX})) begin
      tr_s = tr_s - signed'({2'b00, ONE_FX});
    end
    tb_s     = hue_s - signed'({2'b00, THIRD_FX});
    if (tb_s < 0) begin
      tb_s = tb_s + signed'({2'b00, ONE_FX});
    end
    t_nxt[0] = tr_s[FRAC_BITS:0];
    t_nxt[1] = div_quo[1];
    t_nxt[2] = tb_s[FRAC_BITS:0];
  end

  // q, p and the segment of each channel
  always_comb begin
    linv_s = signed'({3'b000, linv_b1_r});
    if (gray_b1_r) begin
      q_nxt = linv_s;
    end else if (lo_b1_r) begin
      q_nxt = linv_s + signed'({3'b000, prod_b1_r});
    end else begin
      q_nxt = linv_s + signed'({3'b000, sat_b1_r}) - signed'({3'b000, prod_b1_r});
    end
    p_nxt = linv_s + linv_s - q_nxt;
    diff  = q_nxt - p_nxt;
    span_nxt = diff[SW-1] ? '0 : diff[FRAC_BITS+1:0];
    six_t = '0;
    dt    = '0;
    for (int c = 0; c < 3; c++) begin
      if (t_b1_r[c] < SIXTH_FX) begin
        seg_nxt[c] = SEG_RISE;
        six_t      = ({3'b000, t_b1_r[c]} << 2) + ({3'b000, t_b1_r[c]} << 1);
        f_nxt[c]   = six_t[FRAC_BITS:0];
      end else if (t_b1_r[c] < HALF_FX) begin
        seg_nxt[c] = SEG_HIGH;
        f_nxt[c]   = '0;
      end else if (t_b1_r[c] < TWO3_FX) begin
        seg_nxt[c] = SEG_FALL;
        dt         = TWO3_FX - t_b1_r[c];
        six_t      = ({3'b000, dt} << 2) + ({3'b000, dt} << 1);
        f_nxt[c]   = six_t[FRAC_BITS:0];
      end else begin
        seg_nxt[c] = SEG_LOW;
        f_nxt[c]   = '0;
      end
    end
  end

  // slope products
  always_comb begin
    mul_full = '0;
    for (int c = 0; c < 3; c++) begin
      mul_full   = {{(FRAC_BITS+1){1'b0}}, span_b2_r} * {{(FRAC_BITS+2){1'b0}}, f_b2_r[c]};
      mul_nxt[c] = mul_full[2*FRAC_BITS+2:FRAC_BITS];
    end
  end

  // channel value, clamp and scale to a byte
  always_comb begin
    val    = '0;
    valu   = '0;
    scaled = '0;
    for (int c = 0; c < 3; c++) begin
      case (seg_b3_r[c])
        SEG_RISE: val = p_b3_r + signed'({1'b0, mul_b3_r[c]});
        SEG_HIGH: val = q_b3_r;
        SEG_FALL: val = p_b3_r + signed'({1'b0, mul_b3_r[c]});
        SEG_LOW:  val = p_b3_r;
        default:  val = p_b3_r;
      endcase
      if (val < 0) begin
        valu = '0;
      end else if (val > signed'({3'b000, ONE_FX})) begin
        valu = ONE_FX;
      end else begin
        valu = val[FRAC_BITS:0];
      end
      scaled      = {valu, 8'b0} - {8'b0, valu};
      byte_nxt[c] = scaled[FRAC_BITS+7:FRAC_BITS];
    end
  end

  // back valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_b1_r <= 1'b0;
      v_b2_r <= 1'b0;
      v_b3_r <= 1'b0;
      v_b4_r <= 1'b0;
    end else if (en) begin
      v_b1_r <= div_valid;
      v_b2_r <= v_b1_r;
      v_b3_r <= v_b2_r;
      v_b4_r <= v_b3_r;
    end
  end

  // back payload
  always_ff @(posedge clk) begin
    if (en) begin
      linv_b1_r <= linv_nxt;
      sat_b1_r  <= div_quo[0];
      prod_b1_r <= prod_nxt;
      lo_b1_r   <= (linv_nxt < HALF_FX);
      gray_b1_r <= div_side_out[SIDE_W-1];
      a_b1_r    <= div_side_out[FRAC_BITS+8:FRAC_BITS+1];
      p_b2_r    <= p_nxt;
      q_b2_r    <= q_nxt;
      span_b2_r <= span_nxt;
      gray_b2_r <= gray_b1_r;
      a_b2_r    <= a_b1_r;
      p_b3_r    <= p_b2_r;
      q_b3_r    <= q_b2_r;
      gray_b3_r <= gray_b2_r;
      a_b3_r    <= a_b2_r;
      gray_b4_r <= gray_b3_r;
      a_b4_r    <= a_b3_r;
      for (int c = 0; c < 3; c++) begin
        t_b1_r[c]    <= t_nxt[c];
        seg_b2_r[c]  <= seg_nxt[c];
        f_b2_r[c]    <= f_nxt[c];
        seg_b3_r[c]  <= seg_b2_r[c];
        mul_b3_r[c]  <= mul_nxt[c];
        byte_b4_r[c] <= byte_nxt[c];
      end
    end
  end

  // ---------------- output register and skid ----------------
  logic                          ov_r, sv_r;
  logic [3:0][7:0]               od_r, sk_r;
  logic [3:0][7:0]               pix_b4;

  assign pix_b4      = {a_b4_r, byte_b4_r[2], byte_b4_r[1], byte_b4_r[0]};
  assign en          = !sv_r;
  assign in_px.ready = en;

  // output and skid occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else if (!sv_r && v_b4_r) begin
      if (!ov_r || out_px.ready) begin
        ov_r <= 1'b1;
      end else begin
        sv_r <= 1'b1;
      end
    end else if (out_px.ready) begin
      ov_r <= sv_r;
      sv_r <= 1'b0;
    end
  end

  // output and skid data
  always_ff @(posedge clk) begin
    if (!sv_r && v_b4_r) begin
      if (!ov_r || out_px.ready) begin
        od_r <= pix_b4;
      end else begin
        sk_r <= pix_b4;
      end
    end else if (out_px.ready && sv_r) begin
      od_r <= sk_r;
    end
  end

  assign out_px.valid     = ov_r;
  assign out_px.out_red   = od_r[0];
  assign out_px.out_green = od_r[1];
  assign out_px.out_blue  = od_r[2];
  assign out_px.out_alpha = od_r[3];

  // a full skid register always sits behind a full output register
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    sv_r |-> ov_r)
    else $error("skid register full while output register empty");

  // a gray pixel leaves the last stage with three equal channels
  a_gray_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (v_b4_r && gray_b4_r) |->
      (byte_b4_r[0] == byte_b4_r[1] && byte_b4_r[1] == byte_b4_r[2]))
    else $error("gray pixel with unequal channels");

  // a held skid transaction stays put until the receiver takes the output
  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (sv_r && !out_px.ready) |=> (sv_r && $stable(sk_r)))
    else $error("skid transaction lost while receiver stalled");

endmodule

### design/hslinv_div.sv
// two-lane pipelined restoring divider, one quotient bit per stage
module hslinv_div #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned SIDE_W    = 26
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic [1:0][hslinv_pkg::DEN_W-1:0]      in_num,
  input  logic [1:0][hslinv_pkg::DEN_W-1:0]      in_den,
  input  logic [SIDE_W-1:0]                      in_side,
  output logic                                   out_valid,
  output logic [1:0][FRAC_BITS:0]                out_quo,
  output logic [SIDE_W-1:0]                      out_side
);

  localparam int unsigned DW = hslinv_pkg::DEN_W;

  logic [FRAC_BITS:0]               v_r;
  logic [1:0][DW-1:0]               rem_r  [FRAC_BITS+1];
  logic [1:0][DW-1:0]               den_r  [FRAC_BITS+1];
  logic [1:0][FRAC_BITS:0]          quo_r  [FRAC_BITS+1];
  logic [SIDE_W-1:0]                side_r [FRAC_BITS+1];
  logic [1:0][DW-1:0]               rem_nxt [FRAC_BITS+1];
  logic [1:0][FRAC_BITS:0]          quo_nxt [FRAC_BITS+1];

  // entry stage takes the integer bit, later stages one fraction bit each
  always_comb begin
    logic [DW:0] sh;
    sh = '0;
    for (int l = 0; l < 2; l++) begin
      if (in_num[l] >= in_den[l]) begin
        rem_nxt[0][l] = in_num[l] - in_den[l];
        quo_nxt[0][l] = {{FRAC_BITS{1'b0}}, 1'b1};
      end else begin
        rem_nxt[0][l] = in_num[l];
        quo_nxt[0][l] = '0;
      end
    end
    for (int k = 1; k <= FRAC_BITS; k++) begin
      for (int l = 0; l < 2; l++) begin
        sh = {rem_r[k-1][l], 1'b0};
        if (sh >= {1'b0, den_r[k-1][l]}) begin
          rem_nxt[k][l] = DW'(sh - {1'b0, den_r[k-1][l]});
          quo_nxt[k][l] = {quo_r[k-1][l][FRAC_BITS-1:0], 1'b1};
        end else begin
          rem_nxt[k][l] = sh[DW-1:0];
          quo_nxt[k][l] = {quo_r[k-1][l][FRAC_BITS-1:0], 1'b0};
        end
      end
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[FRAC_BITS-1:0], in_valid};
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= rem_nxt[0];
      quo_r[0]  <= quo_nxt[0];
      den_r[0]  <= in_den;
      side_r[0] <= in_side;
      for (int k = 1; k <= FRAC_BITS; k++) begin
        rem_r[k]  <= rem_nxt[k];
        quo_r[k]  <= quo_nxt[k];
        den_r[k]  <= den_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_valid = v_r[FRAC_BITS];
  assign out_quo   = quo_r[FRAC_BITS];
  assign out_side  = side_r[FRAC_BITS];

  // remainder stays below a non-zero divisor
  a_rem_lane0: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[FRAC_BITS] && den_r[FRAC_BITS][0] != '0) |-> rem_r[FRAC_BITS][0] < den_r[FRAC_BITS][0])
    else $error("divider lane 0 remainder out of range");

  a_rem_lane1: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[FRAC_BITS] && den_r[FRAC_BITS][1] != '0) |-> rem_r[FRAC_BITS][1] < den_r[FRAC_BITS][1])
    else $error("divider lane 1 remainder out of range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r))
    else $error("divider valid bits moved while held");

endmodule
